>>> rtl/core/pfms_pkg.sv
// Package for the per-feature mean and standard deviation unit.
// Holds the shared constants, codes, state encoding and interface structs.
// No dependencies.
package pfms_pkg;

  localparam int MAX_FEATURES = 16;
  localparam int IDX_W        = $clog2(MAX_FEATURES);
  localparam int POS_W        = $clog2(MAX_FEATURES + 1);
  localparam logic [15:0] MAX_SAMPLES = 16'hFFFF;

  localparam int WIDE_W  = 80;
  localparam int OPB_W   = 48;
  localparam int CNT_W   = 7;

  localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(48);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(80);
  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(16);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    IT_MUL  = 2'd0,
    IT_DIV  = 2'd1,
    IT_SQRT = 2'd2
  } iter_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MEAN,
    ST_N2,
    ST_SQA,
    ST_SS,
    ST_SQB,
    ST_DEN,
    ST_DIVS,
    ST_ROOT,
    ST_OUT,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic                start;
    iter_op_e            op;
    logic [WIDE_W-1:0]   a;
    logic [OPB_W-1:0]    b;
  } iter_req_t;

  typedef struct packed {
    logic signed [31:0] sum;
    logic [47:0]        sq_sum;
    logic [15:0]        present;
  } entry_t;

endpackage

>>> rtl/core/pfms_store.sv
// Per-feature accumulator store: sum, sum of squares and present count.
// Depends on pfms_pkg.
module pfms_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       add_i,
  input  logic [pfms_pkg::IDX_W-1:0] idx_i,
  input  logic signed [15:0]         value_i,
  output pfms_pkg::entry_t           entry_o
);
  import pfms_pkg::*;

  logic signed [31:0] sum_q     [MAX_FEATURES];
  logic [47:0]        sq_q      [MAX_FEATURES];
  logic [15:0]        present_q [MAX_FEATURES];
  logic signed [31:0] square;

  assign square          = value_i * value_i;
  assign entry_o.sum     = sum_q[idx_i];
  assign entry_o.sq_sum  = sq_q[idx_i];
  assign entry_o.present = present_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FEATURES; i++) begin
        sum_q[i]     <= '0;
        sq_q[i]      <= '0;
        present_q[i] <= '0;
      end
    end else if (clr_i) begin
      for (int i = 0; i < MAX_FEATURES; i++) begin
        sum_q[i]     <= '0;
        sq_q[i]      <= '0;
        present_q[i] <= '0;
      end
    end else if (add_i) begin
      sum_q[idx_i]     <= sum_q[idx_i] + 32'(value_i);
      sq_q[idx_i]      <= sq_q[idx_i] + {16'd0, 32'(unsigned'(square))};
      present_q[idx_i] <= present_q[idx_i] + 16'd1;
    end
  end

endmodule

>>> rtl/core/pfms_iter.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, all on one 80-bit adder/subtractor.
// Depends on pfms_pkg.
module pfms_iter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfms_pkg::iter_req_t         req_i,
  output logic                        done_o,
  output logic [pfms_pkg::WIDE_W-1:0] result_o
);
  import pfms_pkg::*;

  logic              busy_q, done_q;
  iter_op_e          op_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WIDE_W-1:0] acc_q, opa_q;
  logic [OPB_W-1:0]  opb_q;
  logic [WIDE_W-1:0] x, y;
  logic              sub;
  logic [WIDE_W:0]   res;
  logic              borrow;

  always_comb begin
    unique case (op_q)
      IT_MUL: begin
        x   = acc_q;
        y   = opb_q[0] ? opa_q : '0;
        sub = 1'b0;
      end
      IT_DIV: begin
        x   = {31'd0, acc_q[47:0], opa_q[WIDE_W-1]};
        y   = {32'd0, opb_q};
        sub = 1'b1;
      end
      default: begin
        x   = {61'd0, acc_q[16:0], opa_q[31:30]};
        y   = {62'd0, opb_q[15:0], 2'b01};
        sub = 1'b1;
      end
    endcase
    res    = sub ? ({1'b0, x} - {1'b0, y}) : ({1'b0, x} + {1'b0, y});
    borrow = res[WIDE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= IT_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        unique case (req_i.op)
          IT_MUL:  cnt_q <= MUL_STEPS;
          IT_DIV:  cnt_q <= DIV_STEPS;
          default: cnt_q <= SQRT_STEPS;
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      opa_q <= req_i.a;
      opb_q <= (req_i.op == IT_SQRT) ? '0 : req_i.b;
    end else if (busy_q) begin
      unique case (op_q)
        IT_MUL: begin
          acc_q <= res[WIDE_W-1:0];
          opa_q <= {opa_q[WIDE_W-2:0], 1'b0};
          opb_q <= {1'b0, opb_q[OPB_W-1:1]};
        end
        IT_DIV: begin
          acc_q <= borrow ? x : res[WIDE_W-1:0];
          opa_q <= {opa_q[WIDE_W-2:0], ~borrow};
        end
        default: begin
          acc_q <= borrow ? x : res[WIDE_W-1:0];
          opb_q <= {opb_q[OPB_W-2:0], ~borrow};
          opa_q <= {opa_q[WIDE_W-3:0], 2'b00};
        end
      endcase
    end
  end

  assign done_o = done_q;

  always_comb begin
    unique case (op_q)
      IT_MUL:  result_o = acc_q;
      IT_DIV:  result_o = opa_q;
      default: result_o = {64'd0, opb_q[15:0]};
    endcase
  end

endmodule

>>> rtl/core/per_feature_mean_and_std_dev_unit.sv
// Per-feature sample mean and sample standard deviation, top level.
// Add, clear and unused opcodes are accepted with s_axis_tready held high, so they can follow
// back to back; a report with no samples gives its result in the cycle after acceptance.
// Otherwise each feature result becomes valid after a sequence that starts when the report or
// the previous result was taken: load, mean divide, five multiplies, divide and root, with
// early exits skipping the later steps; the input is held off until the last result is taken.
module per_feature_mean_and_std_dev_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // value[15:0]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  input  logic        s_axis_tlast,   // last_in_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // feature_index[3:0], mean_value[19:4], std_dev[35:20], sample_total[51:36], zero pad
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,   // empty_res
  output logic        m_axis_tlast    // last
);
  import pfms_pkg::*;

  state_e            state_q, state_d;
  logic              issued_q, issued_d;
  logic [IDX_W-1:0]  f_q, f_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       sc_q, sc_d;
  logic [POS_W-1:0]  fc_q, fc_d;

  logic [31:0]       sabs_q;
  logic              neg_q;
  logic [47:0]       sq_q;
  logic [16:0]       k_q;
  logic [15:0]       mean_q, std_q;
  logic [31:0]       n2_q;
  logic [WIDE_W-1:0] a_q, tmp_q;

  logic              in_acc, out_acc;
  op_e               op;
  logic              st_clr, st_add;
  logic [IDX_W-1:0]  st_idx;
  entry_t            entry;
  iter_req_t         req;
  logic              it_done;
  logic [WIDE_W-1:0] it_res;
  logic              is_last;
  logic [15:0]       sc_new;
  logic [POS_W-1:0]  fc_new;
  logic [16:0]       two_n, pmin;
  logic [15:0]       mean_mag;

  assign op      = op_e'(s_axis_tuser);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign is_last = ({1'b0, f_q} + POS_W'(1)) == fc_q;

  pfms_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (st_clr),
    .add_i   (st_add),
    .idx_i   (st_idx),
    .value_i (s_axis_tdata),
    .entry_o (entry)
  );

  pfms_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .done_o   (it_done),
    .result_o (it_res)
  );

  // Iterative unit request for each compute state.
  always_comb begin
    req       = '0;
    req.start = !issued_q;
    unique case (state_q)
      ST_MEAN: begin
        req.op = IT_DIV;
        req.a  = {48'd0, sabs_q};
        req.b  = {32'd0, sc_q};
      end
      ST_N2: begin
        req.op = IT_MUL;
        req.a  = {64'd0, sc_q};
        req.b  = {32'd0, sc_q};
      end
      ST_SQA: begin
        req.op = IT_MUL;
        req.a  = {32'd0, sq_q};
        req.b  = {16'd0, n2_q};
      end
      ST_SS: begin
        req.op = IT_MUL;
        req.a  = {48'd0, sabs_q};
        req.b  = {16'd0, sabs_q};
      end
      ST_SQB: begin
        req.op = IT_MUL;
        req.a  = tmp_q;
        req.b  = {31'd0, k_q};
      end
      ST_DEN: begin
        req.op = IT_MUL;
        req.a  = {48'd0, n2_q};
        req.b  = {32'd0, sc_q - 16'd1};
      end
      ST_DIVS: begin
        req.op = IT_DIV;
        req.a  = a_q;
        req.b  = tmp_q[47:0];
      end
      ST_ROOT: begin
        req.op = IT_SQRT;
        req.a  = {48'd0, tmp_q[31:0]};
      end
      default: req.start = 1'b0;
    endcase
  end

  // Sample bookkeeping for an add: a new sample starts on its first element.
  always_comb begin
    sc_new = (pos_q == '0) ? sc_q + 16'd1 : sc_q;
    if (sc_new == 16'd1) begin
      fc_new = (pos_q >= POS_W'(MAX_FEATURES)) ? POS_W'(MAX_FEATURES) : pos_q + POS_W'(1);
    end else begin
      fc_new = fc_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    f_d      = f_q;
    pos_d    = pos_q;
    sc_d     = sc_q;
    fc_d     = fc_q;
    st_clr   = 1'b0;
    st_add   = 1'b0;
    st_idx   = f_q;
    if (req.start) issued_d = 1'b1;
    if (it_done) issued_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        issued_d = 1'b0;
        st_idx   = pos_q[IDX_W-1:0];
        if (in_acc) begin
          unique case (op)
            OP_ADD: begin
              if (!(pos_q == '0 && sc_q == MAX_SAMPLES)) begin
                sc_d   = sc_new;
                fc_d   = fc_new;
                st_add = (pos_q < fc_new) && (pos_q < POS_W'(MAX_FEATURES));
                if (s_axis_tlast) pos_d = '0;
                else if (pos_q < POS_W'(MAX_FEATURES)) pos_d = pos_q + POS_W'(1);
              end
            end
            OP_REPORT: begin
              f_d = '0;
              if (sc_q == '0 || fc_q == '0) state_d = ST_EMPTY;
              else state_d = ST_LOAD;
            end
            OP_CLEAR: begin
              st_clr = 1'b1;
              sc_d   = '0;
              fc_d   = '0;
              pos_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD:  state_d = ST_MEAN;
      ST_MEAN:  if (it_done) state_d = (sc_q < 16'd2) ? ST_OUT : ST_N2;
      ST_N2:    if (it_done) state_d = ST_SQA;
      ST_SQA:   if (it_done) state_d = ST_SS;
      ST_SS:    if (it_done) state_d = ST_SQB;
      ST_SQB:   if (it_done) state_d = (a_q < it_res) ? ST_OUT : ST_DEN;
      ST_DEN:   if (it_done) state_d = ST_DIVS;
      ST_DIVS:  if (it_done) state_d = (it_res[WIDE_W-1:32] != '0) ? ST_OUT : ST_ROOT;
      ST_ROOT:  if (it_done) state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            f_d     = f_q + IDX_W'(1);
            state_d = ST_LOAD;
          end
        end
      end
      ST_EMPTY: if (out_acc) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      f_q      <= '0;
      pos_q    <= '0;
      sc_q     <= '0;
      fc_q     <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      f_q      <= f_d;
      pos_q    <= pos_d;
      sc_q     <= sc_d;
      fc_q     <= fc_d;
    end
  end

  assign two_n    = {sc_q, 1'b0};
  assign pmin     = ({1'b0, entry.present} < two_n) ? {1'b0, entry.present} : two_n;
  assign mean_mag = it_res[15:0];

  // Working registers of the report sequence.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        neg_q  <= entry.sum[31];
        sabs_q <= entry.sum[31] ? 32'(-entry.sum) : 32'(entry.sum);
        sq_q   <= entry.sq_sum;
        k_q    <= two_n - pmin;
      end
      ST_MEAN: if (it_done) begin
        mean_q <= neg_q ? (16'd0 - mean_mag) : mean_mag;
        std_q  <= '0;
      end
      ST_N2:   if (it_done) n2_q <= it_res[31:0];
      ST_SQA:  if (it_done) a_q <= it_res;
      ST_SS:   if (it_done) tmp_q <= it_res;
      ST_SQB:  if (it_done && !(a_q < it_res)) a_q <= a_q - it_res;
      ST_DEN:  if (it_done) tmp_q <= it_res;
      ST_DIVS: if (it_done) begin
        tmp_q <= it_res;
        if (it_res[WIDE_W-1:32] != '0) std_q <= 16'hFFFF;
      end
      ST_ROOT: if (it_done) std_q <= it_res[15:0];
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT) || (state_q == ST_EMPTY);

  always_comb begin
    if (state_q == ST_EMPTY) begin
      m_axis_tdata = {4'd0, sc_q, 16'd0, 16'd0, 4'd0};
      m_axis_tuser = 1'b1;
      m_axis_tlast = 1'b1;
    end else begin
      m_axis_tdata = {4'd0, sc_q, std_q, mean_q, f_q};
      m_axis_tuser = 1'b0;
      m_axis_tlast = is_last;
    end
  end

endmodule
